### rtl/angle_kalman_filter_1d_unit_macros.svh
// Assertion macros used by the checker of the angle Kalman filter unit
`ifndef ANGLE_KALMAN_FILTER_1D_UNIT_MACROS_SVH
`define ANGLE_KALMAN_FILTER_1D_UNIT_MACROS_SVH

// same-cycle implication
`define AKF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AKF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/akf_pkg.sv
// Types, constants and microcode table of the angle Kalman filter unit
package akf_pkg;

  localparam int unsigned CHANNELS_DEFAULT = 2;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROC_INC  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_VAR  = 2'd2;

  localparam logic [23:0] STEP_TIME_RESET = 24'd67109;
  localparam logic [27:0] PROC_INC_RESET  = 28'd68719;
  localparam logic [31:0] MEAS_VAR_RESET  = 32'd2415919104;
  localparam logic [31:0] VAR_RESET       = 32'd1073741824;
  localparam logic [31:0] GAIN_ONE        = 32'h8000_0000;

  localparam int unsigned DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST_BIT = 5'd31;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_RATE,
    MUL_CORR,
    MUL_VAR
  } mul_sel_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PRED,
    OP_DIVINIT,
    OP_DIVSTEP,
    OP_CORR,
    OP_WRBACK
  } op_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_LOOP,
    JMP_END
  } jmp_t;

  localparam int unsigned PC_W = 3;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_MUL_RATE = 3'd0;
  localparam pc_t PC_PRED     = 3'd1;
  localparam pc_t PC_DIV_INIT = 3'd2;
  localparam pc_t PC_DIV_STEP = 3'd3;
  localparam pc_t PC_MUL_CORR = 3'd4;
  localparam pc_t PC_CORR     = 3'd5;
  localparam pc_t PC_WRBACK   = 3'd6;

  typedef struct packed {
    mul_sel_t mul;
    op_t      op;
    jmp_t     jmp;
    pc_t      target;
  } uword_t;

  typedef struct packed {
    logic     load;
    logic     exec;
    mul_sel_t mul;
    op_t      op;
  } ctrl_t;

  typedef struct packed {
    logic div_last;
    logic out_busy;
  } stat_t;

  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    case (pc)
      PC_MUL_RATE: w = '{MUL_RATE, OP_NONE,    JMP_NEXT, PC_MUL_RATE};
      PC_PRED:     w = '{MUL_NONE, OP_PRED,    JMP_NEXT, PC_MUL_RATE};
      PC_DIV_INIT: w = '{MUL_NONE, OP_DIVINIT, JMP_NEXT, PC_MUL_RATE};
      PC_DIV_STEP: w = '{MUL_NONE, OP_DIVSTEP, JMP_LOOP, PC_DIV_STEP};
      PC_MUL_CORR: w = '{MUL_CORR, OP_NONE,    JMP_NEXT, PC_MUL_RATE};
      PC_CORR:     w = '{MUL_VAR,  OP_CORR,    JMP_NEXT, PC_MUL_RATE};
      PC_WRBACK:   w = '{MUL_NONE, OP_WRBACK,  JMP_END,  PC_MUL_RATE};
      default:     w = '{MUL_NONE, OP_NONE,    JMP_END,  PC_MUL_RATE};
    endcase
    return w;
  endfunction

  // clamp a 34-bit signed sum to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic [33:0] v);
    logic [31:0] r;
    if (!v[33] && (v[32:31] != 2'b00)) begin
      r = 32'h7FFF_FFFF;
    end else if (v[33] && (v[32:31] != 2'b11)) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### rtl/angle_kalman_filter_1d_unit.sv
// Per-channel scalar Kalman filter fusing gyro rate and accelerometer angle.
// Each input beat is processed alone by a seven-step microcode program on a
// shared 34x34 multiplier and a one-bit-per-cycle restoring divider. Each beat
// is finished before the next is taken: input ready returns in the cycle
// in which its result appears at the output. The final write-back waits
// while a previous result is still unaccepted at the output.
module angle_kalman_filter_1d_unit import akf_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [63:0]          s_axis_tdata,  // rate [31:0], measured_angle [63:32]
  input  logic                 s_axis_tuser,  // channel [0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [63:0]          m_axis_tdata,  // estimated_angle [31:0], uncertainty_out [63:32]
  output logic                 m_axis_tuser,  // channel_out [0]
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  ctrl_t ctrl;
  stat_t stat;
  logic  busy;
  logic  start;

  assign s_axis_tready = !busy;
  assign start         = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  akf_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  akf_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .stat        (stat),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_channel  (s_axis_tuser),
    .in_rate     (s_axis_tdata[31:0]),
    .in_meas     (s_axis_tdata[63:32]),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_channel (m_axis_tuser),
    .out_angle   (m_axis_tdata[31:0]),
    .out_unc     (m_axis_tdata[63:32])
  );

endmodule

### rtl/akf_seq.sv
// Microcode sequencer: step counter, control store and jump logic
module akf_seq import akf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output ctrl_t ctrl,
  output logic  busy
);

  pc_t    pc;
  uword_t word;
  logic   stall;

  always_comb begin
    word      = ucode(pc);
    stall     = (word.op == OP_WRBACK) && stat.out_busy;
    ctrl.load = start;
    ctrl.exec = busy && !stall;
    ctrl.mul  = word.mul;
    ctrl.op   = word.op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= PC_MUL_RATE;
    end else if (start) begin
      busy <= 1'b1;
      pc   <= PC_MUL_RATE;
    end else if (ctrl.exec) begin
      case (word.jmp)
        JMP_NEXT: pc <= pc + PC_W'(1);
        JMP_LOOP: begin
          if (stat.div_last) begin
            pc <= pc + PC_W'(1);
          end else begin
            pc <= word.target;
          end
        end
        JMP_END: begin
          busy <= 1'b0;
          pc   <= PC_MUL_RATE;
        end
        default: begin
          busy <= 1'b0;
          pc   <= PC_MUL_RATE;
        end
      endcase
    end
  end

endmodule

### rtl/akf_dp.sv
// Datapath: config registers, channel state, shared multiplier, radix-2 divider
module akf_dp import akf_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_t                ctrl,
  output stat_t                stat,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_channel,
  input  logic [31:0]          in_rate,
  input  logic [31:0]          in_meas,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 out_channel,
  output logic [31:0]          out_angle,
  output logic [31:0]          out_unc
);

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [23:0] step_time;
  logic [27:0] proc_inc;
  logic [31:0] meas_var;

  logic [31:0] angle_mem [CHANNELS];
  logic [31:0] var_mem   [CHANNELS];

  logic             ch;
  logic [IDX_W-1:0] idx;
  logic [31:0]      rate;
  logic [31:0]      meas;
  logic [31:0]      pred;
  logic [31:0]      u;
  logic [32:0]      denom;
  logic [32:0]      rem;
  logic [31:0]      numlo;
  logic [31:0]      quot;
  logic [DIV_CNT_W-1:0] cnt;
  logic [32:0]      mag;
  logic             neg;
  logic [31:0]      newang;
  logic signed [67:0] prod;

  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [67:0] prod_rnd24;
  logic signed [67:0] prod_rnd31;
  logic [32:0] delta;
  logic [33:0] ang_sum;
  logic [32:0] u_sum;
  logic [32:0] denom_next;
  logic [63:0] num;
  logic [33:0] trial;
  logic        trial_ge;
  logic [31:0] gain;
  logic [32:0] innov;
  logic [32:0] cm;
  logic [33:0] corr;
  logic [33:0] corr_sum;
  logic [32:0] nu_wide;
  logic [31:0] nu;

  always_comb begin
    case (ctrl.mul)
      MUL_RATE: begin
        mul_a = {{2{rate[31]}}, rate};
        mul_b = {10'd0, step_time};
      end
      MUL_CORR: begin
        mul_a = {1'b0, mag};
        mul_b = {2'd0, gain};
      end
      MUL_VAR: begin
        mul_a = {2'd0, GAIN_ONE - gain};
        mul_b = {2'd0, u};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    prod_rnd24 = prod + 68'sd8388608;
    prod_rnd31 = prod + 68'sd1073741824;
    delta      = prod_rnd24[56:24];
    ang_sum    = {{2{angle_mem[idx][31]}}, angle_mem[idx]} + {delta[32], delta};
    u_sum      = {1'b0, var_mem[idx]} + {5'd0, proc_inc};
    denom_next = {1'b0, u} + {1'b0, meas_var};
    num        = {1'b0, u, 31'd0} + {32'd0, denom_next[32:1]};
    trial      = {rem, numlo[31]};
    trial_ge   = (trial >= {1'b0, denom});
    if (denom == '0) begin
      gain = '0;
    end else if (quot > GAIN_ONE) begin
      gain = GAIN_ONE;
    end else begin
      gain = quot;
    end
    innov    = {meas[31], meas} - {pred[31], pred};
    cm       = prod_rnd31[63:31];
    corr     = neg ? (34'd0 - {1'b0, cm}) : {1'b0, cm};
    corr_sum = {{2{pred[31]}}, pred} + corr;
    nu_wide  = prod_rnd31[63:31];
    nu       = nu_wide[32] ? 32'hFFFF_FFFF : nu_wide[31:0];
  end

  assign stat.div_last = (cnt == '0);
  assign stat.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_time <= STEP_TIME_RESET;
      proc_inc  <= PROC_INC_RESET;
      meas_var  <= MEAS_VAR_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STEP_TIME: step_time <= cfg_data[23:0];
        REG_PROC_INC:  proc_inc  <= cfg_data[27:0];
        REG_MEAS_VAR:  meas_var  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        angle_mem[i] <= '0;
        var_mem[i]   <= VAR_RESET;
      end
      out_valid <= 1'b0;
    end else begin
      if (ctrl.exec && (ctrl.op == OP_WRBACK)) begin
        angle_mem[idx] <= newang;
        var_mem[idx]   <= nu;
        out_valid      <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      ch   <= in_channel;
      idx  <= (CHANNELS > 1) ? IDX_W'(in_channel) : '0;
      rate <= in_rate;
      meas <= in_meas;
    end
    if (ctrl.exec) begin
      if (ctrl.mul != MUL_NONE) begin
        prod <= mul_a * mul_b;
      end
      case (ctrl.op)
        OP_PRED: begin
          pred <= sat32(ang_sum);
          u    <= u_sum[32] ? 32'hFFFF_FFFF : u_sum[31:0];
        end
        OP_DIVINIT: begin
          denom <= denom_next;
          rem   <= {1'b0, num[63:32]};
          numlo <= num[31:0];
          quot  <= '0;
          cnt   <= DIV_LAST_BIT;
          neg   <= innov[32];
          mag   <= innov[32] ? (33'd0 - innov) : innov;
        end
        OP_DIVSTEP: begin
          rem   <= trial_ge ? 33'(trial - {1'b0, denom}) : trial[32:0];
          numlo <= {numlo[30:0], 1'b0};
          quot  <= {quot[30:0], trial_ge};
          cnt   <= cnt - DIV_CNT_W'(1);
        end
        OP_CORR: begin
          newang <= sat32(corr_sum);
        end
        OP_WRBACK: begin
          out_channel <= ch;
          out_angle   <= newang;
          out_unc     <= nu;
        end
        default: ;
      endcase
    end
  end

endmodule

### rtl/akf_checker.sv
// Port-level checker for the angle Kalman filter unit, bound to the top level
`include "angle_kalman_filter_1d_unit_macros.svh"

module akf_checker import akf_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [63:0]          s_axis_tdata,
  input logic                 s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [63:0]          m_axis_tdata,
  input logic                 m_axis_tuser,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [31:0]          cfg_data
);

  `AKF_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled output beat changed")
  `AKF_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready ##1 !s_axis_tready, "input taken again too soon")
  `AKF_ASSERT_NOW(a_ready_with_result, clk, rst, $rose(m_axis_tvalid), s_axis_tready, "result shown while still busy")
  `AKF_ASSERT_NOW(a_cfg_ready, clk, rst, cfg_valid, cfg_ready, "config write refused")

endmodule

bind angle_kalman_filter_1d_unit akf_checker u_akf_checker (.*);

### tb/tb_angle_kalman_filter_1d_unit.sv
// Self-checking testbench for angle_kalman_filter_1d_unit: predicts and checks each beat
module tb_angle_kalman_filter_1d_unit;
  import akf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;  // not a register, writes are dropped
  localparam logic signed [31:0] ANG_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ANG_MIN = 32'sh8000_0000;

  typedef struct {
    logic        ch;
    logic [31:0] angle;
    logic [31:0] variance;
  } estimate_t;

  // Tracks per-channel filter state and the estimates still owed by the block
  class angle_filter_scoreboard;
    logic signed [31:0] angle_st [CHANNELS_DEFAULT];
    logic [31:0]        var_st [CHANNELS_DEFAULT];
    logic [23:0]        dt;
    logic [27:0]        q_inc;
    logic [31:0]        r_var;
    estimate_t          owed_estimates [$];
    int                 errors;
    int                 checked;

    function void clear();
      for (int i = 0; i < CHANNELS_DEFAULT; i++) begin
        angle_st[i] = '0;
        var_st[i] = VAR_RESET;
      end
      dt = STEP_TIME_RESET;
      q_inc = PROC_INC_RESET;
      r_var = MEAS_VAR_RESET;
      owed_estimates.delete();
      errors = 0;
      checked = 0;
    endfunction

    function int pending();
      return owed_estimates.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        REG_STEP_TIME: dt = val[23:0];
        REG_PROC_INC: q_inc = val[27:0];
        REG_MEAS_VAR: r_var = val;
        default: ;
      endcase
    endfunction

    function logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return ANG_MAX;
      if (v < -64'sd2147483648) return ANG_MIN;
      return v[31:0];
    endfunction

    // one predict/update step; the channel state takes the new estimate
    function void filter_step(logic ch, logic signed [31:0] rate, logic signed [31:0] meas);
      int unsigned        slot;
      longint             dt_l, prod, delta, innov, corr;
      logic signed [31:0] pred, newang;
      logic [63:0]        u, denom, gain, mag, cm, nu;
      estimate_t          e;
      slot = ch % CHANNELS_DEFAULT;
      dt_l = longint'(dt);
      prod = longint'(rate) * dt_l;
      delta = (prod + longint'(8388608)) >>> 24;
      pred = clamp32(longint'(angle_st[slot]) + delta);
      u = {32'd0, var_st[slot]} + {36'd0, q_inc};
      if (u > 64'hFFFF_FFFF) u = 64'hFFFF_FFFF;
      denom = u + {32'd0, r_var};
      if (denom == 64'd0) gain = 64'd0;
      else gain = ((u << 31) + (denom >> 1)) / denom;
      if (gain > 64'h8000_0000) gain = 64'h8000_0000;
      innov = longint'(meas) - longint'(pred);
      if (innov < 0) mag = -innov;
      else mag = innov;
      cm = (mag * gain + 64'h4000_0000) >> 31;
      if (innov < 0) corr = -longint'(cm);
      else corr = longint'(cm);
      newang = clamp32(longint'(pred) + corr);
      nu = ((64'h8000_0000 - gain) * u + 64'h4000_0000) >> 31;
      if (nu > 64'hFFFF_FFFF) nu = 64'hFFFF_FFFF;
      angle_st[slot] = newang;
      var_st[slot] = nu[31:0];
      e.ch = ch;
      e.angle = newang;
      e.variance = nu[31:0];
      owed_estimates.push_back(e);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_estimate(logic ch, logic [31:0] angle, logic [31:0] variance);
      estimate_t e;
      if (owed_estimates.size() == 0) begin
        report_mismatch($sformatf("unexpected beat ch=%0d angle=%h var=%h", ch, angle, variance));
        return;
      end
      e = owed_estimates.pop_front();
      checked++;
      if (ch !== e.ch)
        report_mismatch($sformatf("beat %0d channel: got %b want %b", checked, ch, e.ch));
      if (angle !== e.angle)
        report_mismatch($sformatf("beat %0d angle: got %h want %h", checked, angle, e.angle));
      if (variance !== e.variance)
        report_mismatch($sformatf("beat %0d variance: got %h want %h", checked, variance,
                                  e.variance));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [63:0]          s_axis_tdata = '0;  // rate [31:0], measured_angle [63:32]
  logic                 s_axis_tuser = 1'b0;  // channel [0]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [63:0]          m_axis_tdata;  // estimated_angle [31:0], uncertainty_out [63:32]
  logic                 m_axis_tuser;  // channel_out [0]
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  angle_filter_scoreboard sb;
  bit hold_req = 1'b0;
  bit calm = 1'b0;
  int beats_sent = 0;
  int settings_used = 1;

  angle_kalman_filter_1d_unit u_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_estimate(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32]);
  end

  // output side: random stalls, one long hold-off on request, none once calm
  initial begin
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  task automatic send_item(logic ch, logic signed [31:0] rate, logic signed [31:0] meas);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {meas, rate};
    s_axis_tuser <= ch;
    do @(posedge clk); while (!s_axis_tready);
    sb.filter_step(ch, rate, meas);
    beats_sent++;
  endtask

  task automatic idle_gap(int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  task automatic load_settings(logic [31:0] dt, logic [31:0] q, logic [31:0] r, bit poke);
    wait_results_done();
    write_reg(REG_STEP_TIME, dt);
    write_reg(REG_PROC_INC, q);
    write_reg(REG_MEAS_VAR, r);
    if (poke) write_reg(REG_NONE, $urandom);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic random_item(bit gaps);
    logic               ch;
    logic signed [31:0] rate, meas;
    ch = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) < 7) rate = int'($urandom_range(0, 26214400)) - 13107200;
    else rate = $urandom;
    if ($urandom_range(0, 9) < 7)
      meas = sb.angle_st[ch] + (int'($urandom_range(0, 2097152)) - 1048576);
    else meas = $urandom;
    if (gaps && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 12));
    send_item(ch, rate, meas);
  endtask

  initial begin
    logic [31:0] dt, q, r;
    bit          bursty;
    int          rush;
    sb = new;
    sb.clear();
    rush = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings, field extremes
    send_item(1'b0, 32'sd0, 32'sd0);
    send_item(1'b1, -32'sd1, -32'sd1);
    send_item(1'b0, ANG_MAX, ANG_MAX);
    send_item(1'b1, ANG_MIN, ANG_MIN);
    send_item(1'b0, ANG_MIN, ANG_MAX);
    send_item(1'b1, ANG_MAX, ANG_MIN);
    send_item(1'b0, 32'sd0, ANG_MIN);
    send_item(1'b1, 32'sd1, 32'sd0);

    // largest settings: angle saturates both ways
    load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    repeat (3) send_item(1'b0, ANG_MAX, ANG_MAX);
    repeat (3) send_item(1'b1, ANG_MIN, ANG_MIN);

    // zero noise: full gain drives variance to zero, then U+R is zero
    load_settings(32'd0, 32'd0, 32'd0, 1'b0);
    repeat (2) send_item(1'b0, ANG_MAX, 32'sd12345 <<< 16);
    repeat (2) send_item(1'b1, ANG_MIN, -32'sd5 <<< 16);

    // smallest nonzero settings
    load_settings(32'd1, 32'd1, 32'd1, 1'b0);
    repeat (3) random_item(1'b0);

    for (int p = 0; p < 8; p++) begin
      case ($urandom_range(0, 2))
        0: dt = STEP_TIME_RESET;
        1: dt = $urandom;
        default: dt = $urandom_range(0, 1048575);
      endcase
      case ($urandom_range(0, 2))
        0: q = PROC_INC_RESET;
        1: q = $urandom;
        default: q = $urandom_range(0, 65535);
      endcase
      case ($urandom_range(0, 3))
        0: r = $urandom_range(1, 255);
        1: r = $urandom;
        2: r = MEAS_VAR_RESET;
        default: r = 32'hFFFF_FFFF;
      endcase
      load_settings(dt, q, r, 1'($urandom_range(0, 1)));
      if (p == 7) calm = 1'b1;
      bursty = ($urandom_range(0, 2) != 0);
      for (int k = 0; k < 46; k++) begin
        // long output hold-off while the input keeps pushing
        if (p == 2 && k == 10) begin
          hold_req = 1'b1;
          rush = 8;
        end
        random_item(bursty && rush == 0 && !calm);
        if (rush > 0) rush--;
      end
    end

    wait_results_done();
    repeat (60) @(posedge clk);
    $display("Summary: %0d input beats across %0d register settings, %0d results checked",
             beats_sent, settings_used, sb.checked);
    $display("Covered saturation, zero denominator, unused register index; %0d mismatches",
             sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/akf_pkg.sv
rtl/akf_seq.sv
rtl/akf_dp.sv
rtl/angle_kalman_filter_1d_unit.sv
rtl/akf_checker.sv
tb/tb_angle_kalman_filter_1d_unit.sv
